// ----- src/block_bitmap_allocator_defines.svh -----
// ----------------------------------------------------------------------------
// Block bitmap allocator assertion macros
// Shared concurrent assertion wrappers on the block clock and reset.
// ----------------------------------------------------------------------------
`ifndef BLOCK_BITMAP_ALLOCATOR_DEFINES_SVH
`define BLOCK_BITMAP_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define BBA_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("block bitmap allocator: same-cycle check failed");

// Next-cycle implication, disabled during reset
`define BBA_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("block bitmap allocator: next-cycle check failed");

`endif

// ----- src/bba_pkg.sv -----
// ----------------------------------------------------------------------------
// Block bitmap allocator package
// Sizes, status and request codes, and item structs shared by the block.
// ----------------------------------------------------------------------------
package bba_pkg;

   // Bitmap geometry
   localparam int MAX_BLOCKS = 4096;
   localparam int WORD_BITS  = 32;
   localparam int WORD_COUNT = (MAX_BLOCKS + WORD_BITS - 1) / WORD_BITS;
   localparam int ADDR_W     = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
   localparam int BIT_W      = $clog2(WORD_BITS);
   // Wide enough for the limit and for one past the last bitmap position
   localparam int CMP_W      = ADDR_W + BIT_W + 2;

   // Item field widths
   localparam int BLOCK_W  = 12;
   localparam int TOTAL_W  = 13;
   localparam int STATUS_W = 2;

   localparam logic [TOTAL_W-1:0] TOTAL_RESET = TOTAL_W'(4096);

   // Request codes
   localparam logic REQ_ALLOC = 1'b0;
   localparam logic REQ_FREE  = 1'b1;

   // Status codes
   localparam logic [STATUS_W-1:0] ST_OK           = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL         = 2'd1;
   localparam logic [STATUS_W-1:0] ST_ALREADY_FREE = 2'd2;
   localparam logic [STATUS_W-1:0] ST_RANGE        = 2'd3;

   typedef struct packed {
      logic               req_type;
      logic [BLOCK_W-1:0] block_number;
   } bba_req_type;

   typedef struct packed {
      logic [BLOCK_W-1:0]  granted_block;
      logic [STATUS_W-1:0] status;
   } bba_rsp_type;

   // Bitmap write command
   typedef struct packed {
      logic                 en;
      logic [ADDR_W-1:0]    addr;
      logic [WORD_BITS-1:0] word;
   } bba_wr_type;

endpackage

// ----- src/bba_bitmap.sv -----
// ----------------------------------------------------------------------------
// Block bitmap store
// Used-bit words with one write and one registered read port; a word
// never written since reset reads as all free.
// ----------------------------------------------------------------------------
module bba_bitmap import bba_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [ADDR_W-1:0]    rd_addr,
   output logic [WORD_BITS-1:0] rd_word,
   input  bba_wr_type           wr
);

   logic [WORD_BITS-1:0]  mem [WORD_COUNT];
   logic [WORD_COUNT-1:0] vld_ff;
   logic [WORD_BITS-1:0]  rd_data_ff;
   logic                  rd_vld_ff;

   // Write the word and register the read data
   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.word;
      end
      rd_data_ff <= mem[rd_addr];
   end

   // Track written words, cleared at reset
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff    <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         if (wr.en) begin
            vld_ff[wr.addr] <= 1'b1;
         end
         rd_vld_ff <= vld_ff[rd_addr];
      end
   end

   // Unwritten words read as free
   assign rd_word = rd_vld_ff ? rd_data_ff : '0;

endmodule

// ----- src/block_bitmap_allocator.sv -----
// Sequence: a free reads its bitmap word, then checks and clears its bit in S_FREE; an
// allocate scans words from word 0 up in S_SCAN; all, with an out-of-range free, end in S_RESP.
// Throughput: one item at a time; the next item is taken in the cycle after the
// result loads, which waits in S_RESP while the held result is not yet taken.
// Reset: synchronous, active high; the bitmap reads all free at once through
// per-word valid flags, and the block count total_ff returns to 4096.
// ----------------------------------------------------------------------------
// Block bitmap allocator
// First-fit block allocator over a used-bit bitmap with a word-serial scan.
// ----------------------------------------------------------------------------
`include "block_bitmap_allocator_defines.svh"

module block_bitmap_allocator import bba_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  bba_req_type        req_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output bba_rsp_type        rsp_data,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [TOTAL_W-1:0] csr_wdata
);

   // Sequencer states
   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_SCAN = 2'd1;
   localparam logic [1:0] S_FREE = 2'd2;
   localparam logic [1:0] S_RESP = 2'd3;

   logic [1:0]           state_ff, state_in;
   logic [ADDR_W-1:0]    addr_ff, addr_in;
   logic [ADDR_W-1:0]    chk_ff, chk_in;
   logic [BIT_W-1:0]     bit_ff, bit_in;
   bba_rsp_type          res_ff, res_in;
   bba_rsp_type          rsp_ff, rsp_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [TOTAL_W-1:0]   total_ff;

   logic [CMP_W-1:0]     limit;
   logic [CMP_W-1:0]     req_blk;
   logic [ADDR_W-1:0]    req_word;
   logic [ADDR_W-1:0]    rd_addr;
   logic [WORD_BITS-1:0] rd_word;
   logic [WORD_BITS-1:0] allowed;
   logic [WORD_BITS-1:0] free_bits;
   logic [WORD_BITS-1:0] first_hot;
   logic [BIT_W-1:0]     first_idx;
   logic                 last_word;
   logic                 req_fire;
   logic                 rsp_load;
   bba_wr_type           wr;

   assign csr_ready = 1'b1;
   assign req_ready = (state_ff == S_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Saturate the block count at the bitmap size
   assign limit = (CMP_W'(total_ff) > CMP_W'(MAX_BLOCKS)) ? CMP_W'(MAX_BLOCKS)
                                                          : CMP_W'(total_ff);

   // Split the request block into word and bit
   assign req_blk  = CMP_W'(req_data.block_number);
   assign req_word = ADDR_W'(req_blk >> BIT_W);

   // Pick the bitmap word to read next
   always_comb begin
      unique case (state_ff)
         S_IDLE:  rd_addr = (req_data.req_type == REQ_FREE) ? req_word : '0;
         default: rd_addr = addr_ff;
      endcase
   end

   bba_bitmap u_bitmap (
      .clock   (clock),
      .reset   (reset),
      .rd_addr (rd_addr),
      .rd_word (rd_word),
      .wr      (wr)
   );

   // Mask positions at or beyond the limit
   always_comb begin
      for (int i = 0; i < WORD_BITS; i++) begin
         allowed[i] = CMP_W'({chk_ff, BIT_W'(i)}) < limit;
      end
   end

   // Find the lowest clear bit of the checked word
   assign free_bits = ~rd_word & allowed;
   assign first_hot = free_bits & (~free_bits + WORD_BITS'(1));

   always_comb begin
      first_idx = '0;
      for (int i = 0; i < WORD_BITS; i++) begin
         if (first_hot[i]) begin
            first_idx = first_idx | BIT_W'(i);
         end
      end
   end

   assign last_word = ((CMP_W'(chk_ff) + CMP_W'(1)) << BIT_W) >= limit;

   // Sequence the scan, the free and the handoff
   always_comb begin
      state_in = state_ff;
      addr_in  = addr_ff;
      chk_in   = chk_ff;
      bit_in   = bit_ff;
      res_in   = res_ff;
      rsp_load = 1'b0;
      wr       = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               if (req_data.req_type == REQ_ALLOC) begin
                  chk_in   = '0;
                  addr_in  = ADDR_W'(1);
                  state_in = S_SCAN;
               end else if (req_blk >= limit) begin
                  res_in   = '{granted_block: '0, status: ST_RANGE};
                  state_in = S_RESP;
               end else begin
                  chk_in   = req_word;
                  bit_in   = req_blk[BIT_W-1:0];
                  state_in = S_FREE;
               end
            end
         end
         S_SCAN: begin
            if (free_bits != '0) begin
               wr.en    = 1'b1;
               wr.addr  = chk_ff;
               wr.word  = rd_word | first_hot;
               res_in   = '{granted_block: BLOCK_W'({chk_ff, first_idx}), status: ST_OK};
               state_in = S_RESP;
            end else if (last_word) begin
               res_in   = '{granted_block: '0, status: ST_FULL};
               state_in = S_RESP;
            end else begin
               chk_in  = addr_ff;
               addr_in = addr_ff + ADDR_W'(1);
            end
         end
         S_FREE: begin
            if (!rd_word[bit_ff]) begin
               res_in = '{granted_block: '0, status: ST_ALREADY_FREE};
            end else begin
               wr.en   = 1'b1;
               wr.addr = chk_ff;
               wr.word = rd_word & ~(WORD_BITS'(1) << bit_ff);
               res_in  = '{granted_block: '0, status: ST_OK};
            end
            state_in = S_RESP;
         end
         S_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Hold the result item until taken
   assign rsp_in       = rsp_load ? res_ff : rsp_ff;
   assign rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_ready);

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         total_ff     <= TOTAL_RESET;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            total_ff <= csr_wdata;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      addr_ff <= addr_in;
      chk_ff  <= chk_in;
      bit_ff  <= bit_in;
      res_ff  <= res_in;
      rsp_ff  <= rsp_in;
   end

   // Only a successful allocate carries a block number
   `BBA_ASSERT_SAME(a_granted_zero, rsp_valid && (rsp_data.status != ST_OK), rsp_data.granted_block == '0)
   // An accepted item closes the input until its result is handed off
   `BBA_ASSERT_NEXT(a_busy_after_accept, req_valid && req_ready, !req_ready)
   // A new result appears only from the handoff state
   `BBA_ASSERT_SAME(a_load_from_resp, rsp_load, state_ff == S_RESP)

endmodule
